### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

### rtl/core/otbsr_pkg.sv
package otbsr_pkg;

  // receive status codes
  localparam logic [1:0] RX_NONE    = 2'd0;
  localparam logic [1:0] RX_SUCCESS = 2'd1;
  localparam logic [1:0] RX_INVALID = 2'd2;
  localparam logic [1:0] RX_TIMEOUT = 2'd3;

  // message types
  localparam logic [2:0] MT_READ_DATA    = 3'd0;
  localparam logic [2:0] MT_READ_ACK     = 3'd4;
  localparam logic [2:0] MT_WRITE_ACK    = 3'd5;
  localparam logic [2:0] MT_DATA_INVALID = 3'd6;
  localparam logic [2:0] MT_UNKNOWN_ID   = 3'd7;

  // data IDs
  localparam logic [7:0] ID_STATUS     = 8'd0;
  localparam logic [7:0] ID_CH_SETPT   = 8'd1;
  localparam logic [7:0] ID_SLAVE_CFG  = 8'd3;
  localparam logic [7:0] ID_COMMAND    = 8'd4;
  localparam logic [7:0] ID_FAULT      = 8'd5;
  localparam logic [7:0] ID_MOD_LEVEL  = 8'd17;
  localparam logic [7:0] ID_BOILER_T   = 8'd25;
  localparam logic [7:0] ID_DHW_T      = 8'd26;
  localparam logic [7:0] ID_OUTSIDE_T  = 8'd27;
  localparam logic [7:0] ID_RETURN_T   = 8'd28;
  localparam logic [7:0] ID_DHW_BOUNDS = 8'd48;
  localparam logic [7:0] ID_CH_BOUNDS  = 8'd49;
  localparam logic [7:0] ID_DHW_SETPT  = 8'd56;

  // link state codes
  localparam logic [1:0] LINK_SAME = 2'd0;
  localparam logic [1:0] LINK_GOOD = 2'd1;
  localparam logic [1:0] LINK_LOST = 2'd2;

  // setpoint store codes
  localparam logic [1:0] SP_NONE = 2'd0;
  localparam logic [1:0] SP_CH   = 2'd1;
  localparam logic [1:0] SP_DHW  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 8;
  localparam logic [CFG_AW-1:0] REG_MEMBER_ID        = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CONTROL_ON_OFF   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CH_MIN           = 3'd2;
  localparam logic [CFG_AW-1:0] REG_CH_MAX           = 3'd3;
  localparam logic [CFG_AW-1:0] REG_DHW_MIN          = 3'd4;
  localparam logic [CFG_AW-1:0] REG_DHW_MAX          = 3'd5;
  localparam logic [CFG_AW-1:0] REG_SENSOR_PRESENT   = 3'd6;
  localparam logic [CFG_AW-1:0] REG_REPLY_ON_INVALID = 3'd7;

  localparam logic [2:0] TIMEOUT_THRESHOLD = 3'd5;

  // sensor_present bits
  localparam int unsigned SENS_DHW     = 0;
  localparam int unsigned SENS_OUTSIDE = 1;
  localparam int unsigned SENS_RETURN  = 2;

  typedef struct packed {
    logic [1:0]         rx_status;
    logic [31:0]        request_frame;
    logic signed [15:0] boiler_temp;
    logic signed [15:0] return_temp;
    logic signed [15:0] dhw_temp;
    logic signed [15:0] outside_temp;
    logic [6:0]         mod_level;
    logic               ch_active;
    logic               dhw_active;
    logic               flame_on;
  } in_item_t;

  typedef struct packed {
    logic               send_reply;
    logic [31:0]        reply_frame;
    logic [1:0]         link_state;
    logic               master_cmd_valid;
    logic               master_ch_enable;
    logic               master_dhw_enable;
    logic [1:0]         setpoint_written;
    logic signed [15:0] setpoint_value;
  } out_item_t;

  typedef struct packed {
    logic [7:0] member_id;
    logic       control_on_off;
    logic [7:0] ch_min;
    logic [7:0] ch_max;
    logic [7:0] dhw_min;
    logic [7:0] dhw_max;
    logic [2:0] sensor_present;
    logic       reply_on_invalid;
  } cfg_t;

  typedef struct packed {
    logic [15:0] ch_setpoint;
    logic [15:0] dhw_setpoint;
    logic [2:0]  timeout_run;
  } state_t;

endpackage

### rtl/core/opentherm_boiler_slave_responder.sv
// OpenTherm boiler slave responder.
// Input channel (in_valid / in_stall / in_item): one received master frame
// with its receive status and the current boiler readings per item.
// Result channel (out_valid / out_stall / out_item): exactly one result item
// per input item, in order: the reply frame (even parity in bit 31), link
// status, master enable bits and any newly stored setpoint.
// Config port (cfg_valid / cfg_ready / cfg_addr / cfg_wdata): always ready;
// write registers only while no items are in flight.
// The item passes through the input register, then the reply logic into the
// output register, before out_valid rises and the result can be taken.
// Throughput: one item per cycle while out_stall is low;
// the stored setpoints and timeout count update as an item enters the
// output register, so the next item already sees them.
// When out_stall is held, the output register keeps its item and the input
// register absorbs one more item; after that in_stall rises.
// Reset (rst_n low, synchronous) empties both registers, clears the config
// registers, both setpoints and the timeout count.
`include "assert_macros.svh"

module opentherm_boiler_slave_responder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  otbsr_pkg::in_item_t                   in_item,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output otbsr_pkg::out_item_t                  out_item,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [otbsr_pkg::CFG_AW-1:0]          cfg_addr,
  input  logic [otbsr_pkg::CFG_DW-1:0]          cfg_wdata
);

  otbsr_pkg::cfg_t      cfg_r;
  otbsr_pkg::state_t    st_r;
  otbsr_pkg::state_t    st_nxt;
  otbsr_pkg::in_item_t  s1_item_r;
  logic                 s1_valid_r;
  otbsr_pkg::out_item_t out_item_r;
  otbsr_pkg::out_item_t res_nxt;
  logic                 out_valid_r;
  logic                 in_accept;
  logic                 out_load;

  assign cfg_ready = 1'b1;
  assign out_load  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  otbsr_reply u_reply (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (s1_item_r),
    .res    (res_nxt),
    .st_nxt (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        otbsr_pkg::REG_MEMBER_ID:        cfg_r.member_id        <= cfg_wdata;
        otbsr_pkg::REG_CONTROL_ON_OFF:   cfg_r.control_on_off   <= cfg_wdata[0];
        otbsr_pkg::REG_CH_MIN:           cfg_r.ch_min           <= cfg_wdata;
        otbsr_pkg::REG_CH_MAX:           cfg_r.ch_max           <= cfg_wdata;
        otbsr_pkg::REG_DHW_MIN:          cfg_r.dhw_min          <= cfg_wdata;
        otbsr_pkg::REG_DHW_MAX:          cfg_r.dhw_max          <= cfg_wdata;
        otbsr_pkg::REG_SENSOR_PRESENT:   cfg_r.sensor_present   <= cfg_wdata[2:0];
        otbsr_pkg::REG_REPLY_ON_INVALID: cfg_r.reply_on_invalid <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= in_accept || (s1_valid_r && !out_load);
      out_valid_r <= out_load || (out_valid_r && out_stall);
      if (out_load) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
    end
    if (out_load) begin
      out_item_r <= res_nxt;
    end
  end

  `ASSERT_CLK(a_timeout_sat, clk, rst_n, st_r.timeout_run <= otbsr_pkg::TIMEOUT_THRESHOLD)
  `ASSERT_CLK(a_stall_full, clk, rst_n, in_stall |-> (s1_valid_r && out_valid_r))
  `ASSERT_CLK(a_parity, clk, rst_n, (out_valid_r && out_item_r.send_reply) |-> !(^out_item_r.reply_frame))
  `ASSERT_NEVER(a_silent_frame, clk, rst_n, out_valid_r && !out_item_r.send_reply && (out_item_r.reply_frame != 32'h0))
  `ASSERT_CLK(a_ch_store, clk, rst_n, (out_load && res_nxt.setpoint_written == otbsr_pkg::SP_CH) |=> (st_r.ch_setpoint == out_item_r.setpoint_value))
  `ASSERT_CLK(a_dhw_store, clk, rst_n, (out_load && res_nxt.setpoint_written == otbsr_pkg::SP_DHW) |=> (st_r.dhw_setpoint == out_item_r.setpoint_value))

endmodule

### rtl/core/otbsr_reply.sv
module otbsr_reply (
  input  otbsr_pkg::cfg_t      cfg,
  input  otbsr_pkg::state_t    st,
  input  otbsr_pkg::in_item_t  item,
  output otbsr_pkg::out_item_t res,
  output otbsr_pkg::state_t    st_nxt
);

  function automatic logic [15:0] temp_word(input logic signed [15:0] t);
    logic [15:0] w;
    if (t < 0) begin
      w = 16'h0000;
    end else if (t > 16'sd25600) begin
      w = 16'd25600;
    end else begin
      w = t;
    end
    return w;
  endfunction

  function automatic logic signed [15:0] bound_fix(input logic [7:0] deg);
    logic signed [15:0] b;
    if (deg[7]) begin
      b = 16'sh7FFF;
    end else begin
      b = {deg, 8'h00};
    end
    return b;
  endfunction

  function automatic logic [31:0] frame_of(input logic [2:0] mt, input logic [7:0] id,
                                           input logic [15:0] d);
    logic [31:0] f;
    f = {1'b0, mt, 4'h0, id, d};
    f[31] = ^f[30:0];
    return f;
  endfunction

  logic [2:0]         rtype;
  logic [7:0]         id;
  logic [15:0]        rdata;
  logic [15:0]        dout;
  logic [2:0]         mtype;
  logic               hot;
  logic signed [15:0] sp_lo;
  logic signed [15:0] sp_hi;
  logic signed [15:0] sp_req;
  logic signed [15:0] sp_clamped;
  logic [6:0]         mod_sat;

  always_comb begin
    rtype  = item.request_frame[30:28];
    id     = item.request_frame[23:16];
    rdata  = item.request_frame[15:0];
    hot    = (id == otbsr_pkg::ID_DHW_SETPT);
    sp_lo  = bound_fix(hot ? cfg.dhw_min : cfg.ch_min);
    sp_hi  = bound_fix(hot ? cfg.dhw_max : cfg.ch_max);
    sp_req = rdata;
    if (sp_req < sp_lo) begin
      sp_clamped = sp_lo;
    end else if (sp_req > sp_hi) begin
      sp_clamped = sp_hi;
    end else begin
      sp_clamped = sp_req;
    end
    mod_sat = (item.mod_level > 7'd100) ? 7'd100 : item.mod_level;

    res    = '0;
    st_nxt = st;
    mtype  = otbsr_pkg::MT_READ_ACK;
    dout   = rdata;

    case (item.rx_status)
      otbsr_pkg::RX_INVALID: begin
        if (cfg.reply_on_invalid) begin
          res.send_reply  = 1'b1;
          res.reply_frame = frame_of(otbsr_pkg::MT_DATA_INVALID, id, 16'h0000);
        end
      end
      otbsr_pkg::RX_TIMEOUT: begin
        if (st.timeout_run >= otbsr_pkg::TIMEOUT_THRESHOLD) begin
          st_nxt.timeout_run = otbsr_pkg::TIMEOUT_THRESHOLD;
          res.link_state     = otbsr_pkg::LINK_LOST;
        end else begin
          st_nxt.timeout_run = st.timeout_run + 3'd1;
        end
      end
      otbsr_pkg::RX_SUCCESS: begin
        st_nxt.timeout_run = '0;
        res.link_state     = otbsr_pkg::LINK_GOOD;
        res.send_reply     = 1'b1;
        case (id)
          otbsr_pkg::ID_STATUS: begin
            res.master_cmd_valid  = 1'b1;
            res.master_ch_enable  = rdata[8];
            res.master_dhw_enable = rdata[9];
            dout = {rdata[15:8], 4'h0, item.flame_on, item.dhw_active, item.ch_active, 1'b0};
          end
          otbsr_pkg::ID_SLAVE_CFG: begin
            dout = {4'h0, 1'b1, 1'b0, cfg.control_on_off, 1'b0, cfg.member_id};
          end
          otbsr_pkg::ID_COMMAND: begin
            if (rdata[15:8] == 8'd1) begin
              dout[7] = 1'b1;
            end
          end
          otbsr_pkg::ID_FAULT: begin
            dout = 16'h0000;
          end
          otbsr_pkg::ID_DHW_BOUNDS: begin
            dout = {cfg.dhw_max, cfg.dhw_min};
          end
          otbsr_pkg::ID_CH_BOUNDS: begin
            dout = {cfg.ch_max, cfg.ch_min};
          end
          otbsr_pkg::ID_CH_SETPT, otbsr_pkg::ID_DHW_SETPT: begin
            if (rtype == otbsr_pkg::MT_READ_DATA) begin
              dout = temp_word(hot ? st.dhw_setpoint : st.ch_setpoint);
            end else begin
              mtype              = otbsr_pkg::MT_WRITE_ACK;
              res.setpoint_value = sp_clamped;
              if (hot) begin
                st_nxt.dhw_setpoint  = sp_clamped;
                res.setpoint_written = otbsr_pkg::SP_DHW;
              end else begin
                st_nxt.ch_setpoint   = sp_clamped;
                res.setpoint_written = otbsr_pkg::SP_CH;
              end
            end
          end
          otbsr_pkg::ID_MOD_LEVEL: begin
            dout = {1'b0, mod_sat, 8'h00};
          end
          otbsr_pkg::ID_BOILER_T: begin
            dout = temp_word(item.boiler_temp);
          end
          otbsr_pkg::ID_DHW_T: begin
            if (cfg.sensor_present[otbsr_pkg::SENS_DHW]) begin
              dout = temp_word(item.dhw_temp);
            end else begin
              mtype = otbsr_pkg::MT_UNKNOWN_ID;
            end
          end
          otbsr_pkg::ID_OUTSIDE_T: begin
            if (cfg.sensor_present[otbsr_pkg::SENS_OUTSIDE]) begin
              dout = temp_word(item.outside_temp);
            end else begin
              mtype = otbsr_pkg::MT_UNKNOWN_ID;
            end
          end
          otbsr_pkg::ID_RETURN_T: begin
            if (cfg.sensor_present[otbsr_pkg::SENS_RETURN]) begin
              dout = temp_word(item.return_temp);
            end else begin
              mtype = otbsr_pkg::MT_UNKNOWN_ID;
            end
          end
          default: begin
            mtype = otbsr_pkg::MT_UNKNOWN_ID;
          end
        endcase
        res.reply_frame = frame_of(mtype, id, dout);
      end
      default: begin
      end
    endcase
  end

endmodule
